@@ rtl/stbs_pkg.sv @@
// Package for the sorted table binary search block.
// Holds the sizing constants, mode and register codes, and the command and status
// structs shared by the controller and the datapath. Depends on nothing.
package stbs_pkg;

    // Table sizing.
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int POS_W       = $clog2(TABLE_DEPTH);

    // Fixed field widths at the ports.
    localparam int SIZE_W      = 11;
    localparam int MODE_W      = 3;
    localparam int ENTRY_POS_W = 10;
    localparam int KEY_IN_W    = 32;
    localparam int RES_POS_W   = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    // Request commands.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 1'd1;

    // Search modes.
    localparam logic [MODE_W-1:0] MODE_LAST_LE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT_LE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP_LE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIRST_GE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EXACT    = 3'd4;

    // Table read address source.
    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_TOP,
        ADDR_MID,
        ADDR_LO,
        ADDR_HI,
        ADDR_LO_INC,
        ADDR_LO_DEC
    } addr_sel_t;

    // Source of the delivered result.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_ZERO,
        RES_LO,
        RES_HI,
        RES_TOP
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      table_write;
        logic      load_key;
        logic      load_first;
        addr_sel_t addr_sel;
        logic      init_bounds;
        logic      bisect_step;
        logic      bisect_ge;
        logic      lo_inc;
        logic      lo_dec;
        logic      out_load;
        res_sel_t  res_sel;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              key_gt_last;
        logic              key_lt_first;
        logic              key_le_first;
        logic              span_open;
        logic              rd_eq_key;
        logic              lo_below_top;
        logic              lo_nonzero;
    } dp_status_t;

endpackage

@@ rtl/stbs_if.sv @@
// Request and response channel interfaces of the sorted table binary search block.
// Each carries valid, ready and the payload. Depends on stbs_pkg.
interface stbs_req_if
    import stbs_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [ENTRY_POS_W-1:0] entry_position;
    logic [KEY_IN_W-1:0]    key_value;

    modport source (output valid, output command, output entry_position, output key_value,
                    input ready);
    modport sink (input valid, input command, input entry_position, input key_value,
                  output ready);
endinterface

interface stbs_rsp_if
    import stbs_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [RES_POS_W-1:0] result_position;

    modport source (output valid, output found, output result_position, input ready);
    modport sink (input valid, input found, input result_position, output ready);
endinterface

@@ rtl/stbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/stbs_dp.sv @@
// Datapath of the sorted table binary search block: configuration registers, key table,
// search bounds, comparators and the response payload register.
// Depends on stbs_pkg and stbs_ram.
module stbs_dp
    import stbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [ENTRY_POS_W-1:0] entry_position,
    input  logic [KEY_IN_W-1:0]    key_value,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   found,
    output logic [RES_POS_W-1:0]   result_position
);

    logic [SIZE_W-1:0]    tsize_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] first_reg;
    logic [POS_W-1:0]     top_reg;
    logic [POS_W-1:0]     lo_reg;
    logic [POS_W-1:0]     hi_reg;
    logic                 found_reg;
    logic [RES_POS_W-1:0] pos_reg;

    logic [POS_W-1:0]     top_calc;
    logic [POS_W:0]       mid_sum;
    logic [POS_W-1:0]     mid;
    logic [POS_W-1:0]     raddr;
    logic [KEY_WIDTH-1:0] rdata;
    logic                 we;
    logic                 go_high;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg <= SIZE_W'(1);
            mode_reg  <= MODE_LAST_LE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TABLE_SIZE:  tsize_reg <= SIZE_W'(cfg_data);
                REG_SEARCH_MODE: mode_reg  <= MODE_W'(cfg_data);
                default:         ;
            endcase
        end
    end

    // Last searched position: a size of zero acts as one, and a size above the depth
    // acts as the depth.
    always_comb
    begin
        if (tsize_reg == '0)
        begin
            top_calc = '0;
        end
        else if (int'(tsize_reg) > TABLE_DEPTH)
        begin
            top_calc = POS_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            top_calc = POS_W'(tsize_reg - SIZE_W'(1));
        end
    end

    // Midpoint of the current bounds.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[POS_W:1];

    // Read address selection.
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_ZERO:   raddr = '0;
            ADDR_TOP:    raddr = top_reg;
            ADDR_MID:    raddr = mid;
            ADDR_LO:     raddr = lo_reg;
            ADDR_HI:     raddr = hi_reg;
            ADDR_LO_INC: raddr = lo_reg + POS_W'(1);
            ADDR_LO_DEC: raddr = lo_reg - POS_W'(1);
            default:     raddr = '0;
        endcase
    end

    // Writes beyond the table depth are dropped.
    assign we = cmd.table_write && (int'(entry_position) < TABLE_DEPTH);

    stbs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (POS_W'(entry_position)),
        .wdata (KEY_WIDTH'(key_value)),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Bisection direction for the probe just read.
    assign go_high = cmd.bisect_ge ? (rdata >= key_reg) : (rdata > key_reg);

    // Search registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= KEY_WIDTH'(key_value);
            top_reg <= top_calc;
        end
        if (cmd.load_first)
        begin
            first_reg <= rdata;
        end
        if (cmd.init_bounds)
        begin
            lo_reg <= '0;
            hi_reg <= top_reg;
        end
        else if (cmd.bisect_step)
        begin
            if (go_high)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid;
            end
        end
        else if (cmd.lo_inc)
        begin
            lo_reg <= lo_reg + POS_W'(1);
        end
        else if (cmd.lo_dec)
        begin
            lo_reg <= lo_reg - POS_W'(1);
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.res_sel)
                RES_ZERO:
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= '0;
                end
                RES_LO:
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= RES_POS_W'(lo_reg);
                end
                RES_HI:
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= RES_POS_W'(hi_reg);
                end
                RES_TOP:
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= RES_POS_W'(top_reg);
                end
                default:
                begin
                    found_reg <= 1'b0;
                    pos_reg   <= '0;
                end
            endcase
        end
    end

    assign found           = found_reg;
    assign result_position = pos_reg;

    // Status toward the controller.
    assign status.mode         = mode_reg;
    assign status.key_gt_last  = key_reg > rdata;
    assign status.key_lt_first = key_reg < first_reg;
    assign status.key_le_first = key_reg <= first_reg;
    assign status.span_open    = {1'b0, hi_reg} > ({1'b0, lo_reg} + (POS_W + 1)'(1));
    assign status.rd_eq_key    = rdata == key_reg;
    assign status.lo_below_top = lo_reg < top_reg;
    assign status.lo_nonzero   = lo_reg != '0;

endmodule

@@ rtl/stbs_ctrl.sv @@
// Controller of the sorted table binary search block: sequences the end checks, the
// bisection and the scans over equal keys, and owns the handshakes. Depends on stbs_pkg.
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_command,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_CHECK,
        S_PROBE,
        S_CMP,
        S_SCANR,
        S_SCANR_CMP,
        S_SCANL,
        S_SCANL_CMP,
        S_EQ_HI,
        S_EQ_HI_CMP,
        S_EQ_LO_CMP,
        S_DONE
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;
    logic     out_valid_reg, out_valid_next;

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_sel_reg   <= RES_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_sel_reg   <= res_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        res_sel_next   = res_sel_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.addr_sel   = ADDR_ZERO;
        cmd.res_sel    = res_sel_reg;
        cmd.bisect_ge  = (status.mode == MODE_FIRST_GE) || (status.mode == MODE_EXACT);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_command == CMD_SEARCH)
                    begin
                        cmd.load_key = 1'b1;
                        state_next   = S_RD_FIRST;
                    end
                    else
                    begin
                        cmd.table_write = 1'b1;
                    end
                end
            end

            // Fetch the first entry, then the last searched entry.
            S_RD_FIRST:
            begin
                cmd.addr_sel = ADDR_ZERO;
                state_next   = S_RD_LAST;
            end

            S_RD_LAST:
            begin
                cmd.addr_sel   = ADDR_TOP;
                cmd.load_first = 1'b1;
                state_next     = S_CHECK;
            end

            // Range checks against the end entries decide the early answers.
            S_CHECK:
            begin
                cmd.init_bounds = 1'b1;
                state_next      = S_DONE;
                res_sel_next    = RES_NONE;
                unique case (status.mode) inside
                    MODE_LAST_LE, MODE_LEFT_LE, MODE_EXACT:
                    begin
                        if (!status.key_gt_last && !status.key_lt_first)
                        begin
                            state_next = S_PROBE;
                        end
                    end
                    MODE_CLAMP_LE:
                    begin
                        if (status.key_gt_last)
                        begin
                            res_sel_next = RES_TOP;
                        end
                        else if (!status.key_lt_first)
                        begin
                            state_next = S_PROBE;
                        end
                    end
                    MODE_FIRST_GE:
                    begin
                        if (!status.key_gt_last)
                        begin
                            if (status.key_le_first)
                            begin
                                res_sel_next = RES_ZERO;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                    end
                    default:
                    begin
                        res_sel_next = RES_NONE;
                    end
                endcase
            end

            // Bisection: probe the midpoint while the bounds are more than one apart.
            S_PROBE:
            begin
                if (status.span_open)
                begin
                    cmd.addr_sel = ADDR_MID;
                    state_next   = S_CMP;
                end
                else
                begin
                    unique case (status.mode) inside
                        MODE_FIRST_GE:
                        begin
                            res_sel_next = RES_HI;
                            state_next   = S_DONE;
                        end
                        MODE_EXACT:
                        begin
                            state_next = S_EQ_HI;
                        end
                        default:
                        begin
                            state_next = S_SCANR;
                        end
                    endcase
                end
            end

            S_CMP:
            begin
                cmd.bisect_step = 1'b1;
                state_next      = S_PROBE;
            end

            // Scan right over entries equal to the key.
            S_SCANR:
            begin
                if (status.lo_below_top)
                begin
                    cmd.addr_sel = ADDR_LO_INC;
                    state_next   = S_SCANR_CMP;
                end
                else if (status.mode == MODE_LEFT_LE)
                begin
                    state_next = S_SCANL;
                end
                else
                begin
                    res_sel_next = RES_LO;
                    state_next   = S_DONE;
                end
            end

            S_SCANR_CMP:
            begin
                if (status.rd_eq_key)
                begin
                    cmd.lo_inc = 1'b1;
                    state_next = S_SCANR;
                end
                else if (status.mode == MODE_LEFT_LE)
                begin
                    state_next = S_SCANL;
                end
                else
                begin
                    res_sel_next = RES_LO;
                    state_next   = S_DONE;
                end
            end

            // Scan left over entries equal to the key, for the leftmost mode.
            S_SCANL:
            begin
                if (status.lo_nonzero)
                begin
                    cmd.addr_sel = ADDR_LO_DEC;
                    state_next   = S_SCANL_CMP;
                end
                else
                begin
                    res_sel_next = RES_LO;
                    state_next   = S_DONE;
                end
            end

            S_SCANL_CMP:
            begin
                if (status.rd_eq_key)
                begin
                    cmd.lo_dec = 1'b1;
                    state_next = S_SCANL;
                end
                else
                begin
                    res_sel_next = RES_LO;
                    state_next   = S_DONE;
                end
            end

            // Exact match: check the upper bound, then the lower one.
            S_EQ_HI:
            begin
                cmd.addr_sel = ADDR_HI;
                state_next   = S_EQ_HI_CMP;
            end

            S_EQ_HI_CMP:
            begin
                if (status.rd_eq_key)
                begin
                    res_sel_next = RES_HI;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.addr_sel = ADDR_LO;
                    state_next   = S_EQ_LO_CMP;
                end
            end

            S_EQ_LO_CMP:
            begin
                res_sel_next = status.rd_eq_key ? RES_LO : RES_NONE;
                state_next   = S_DONE;
            end

            // Hand the result to the response register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// Sorted table binary search, top level: joins the controller and the datapath to the
// request and response channels and the configuration write port.
// Depends on stbs_pkg, stbs_if, stbs_ctrl and stbs_dp.
//
// The block keeps a table of TABLE_DEPTH unsigned keys that software loads in ascending
// order with write requests; a write request gives no response. A search request gives
// one response with a found flag and a position chosen by search_mode, over the first
// table_size entries. The block works on one search at a time, all through the single
// read port of the key table whose data arrive in the cycle after the address. A search
// first reads the first and the last searched entries; the end checks against them may
// settle it. Otherwise it bisects, reading and comparing the midpoint while the bounds
// are more than one apart, and then, by mode, answers with the upper bound, scans over
// entries equal to the search key, or checks both bounds for an exact match. A finished
// response waits in its own register, so a new request is taken while it is still
// pending; the next search waits in its last step only while that register is still
// held. The user must write configuration only while no search is in flight; the block
// itself does not enforce it.
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    stbs_req_if.sink              req,
    stbs_rsp_if.source            rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    stbs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Table, bounds and result datapath.
    stbs_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .entry_position  (req.entry_position),
        .key_value       (req.key_value),
        .cmd             (cmd),
        .status          (status),
        .found           (rsp.found),
        .result_position (rsp.result_position)
    );

endmodule

@@ verif/stbs_tb_pkg.sv @@
// Scoreboard for the sorted table binary search testbench.
// Keeps its own copy of the key table and the two registers and predicts every search response.
// Depends on stbs_pkg.
package stbs_tb_pkg;
    import stbs_pkg::*;

    // One expected search response.
    typedef struct {
        logic                 found;
        logic [RES_POS_W-1:0] position;
    } search_result_t;

    class search_scoreboard;
        logic [KEY_WIDTH-1:0] table_key [TABLE_DEPTH];
        logic [SIZE_W-1:0]    size_reg;
        logic [MODE_W-1:0]    mode_reg;
        search_result_t       awaited_results [$];
        int                   errors;

        function new();
            foreach (table_key[i])
                table_key[i] = '0;
            size_reg = 1;
            mode_reg = MODE_LAST_LE;
            errors   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_TABLE_SIZE)
                size_reg = data[SIZE_W-1:0];
            else if (index == REG_SEARCH_MODE)
                mode_reg = data[MODE_W-1:0];
        endfunction

        // A size of zero searches one entry; sizes past the table search all of it.
        function int active_size();
            if (size_reg == 0)
                return 1;
            if (size_reg > TABLE_DEPTH)
                return TABLE_DEPTH;
            return int'(size_reg);
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // Bisect for the last entry at or below x, then step right over keys equal to x.
        function int last_at_or_below(logic [KEY_WIDTH-1:0] x, int n);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = n - 1;
            while (hi > lo + 1)
            begin
                mid = (lo + hi) / 2;
                if (table_key[mid] > x)
                    hi = mid;
                else
                    lo = mid;
            end
            while (lo < n - 1 && table_key[lo + 1] == x)
                lo++;
            return lo;
        endfunction

        // Bisect for the first entry at or above x; returns the upper bound, lower one in lo.
        function int bisect_ge(logic [KEY_WIDTH-1:0] x, int n, output int lo);
            int hi;
            int mid;
            lo = 0;
            hi = n - 1;
            while (hi > lo + 1)
            begin
                mid = (lo + hi) / 2;
                if (table_key[mid] >= x)
                    hi = mid;
                else
                    lo = mid;
            end
            return hi;
        endfunction

        // Work out the response of one search under the current size and mode.
        function search_result_t locate(logic [KEY_WIDTH-1:0] x);
            search_result_t       res;
            int                   n;
            int                   lo;
            int                   hi;
            logic [KEY_WIDTH-1:0] first_key;
            logic [KEY_WIDTH-1:0] last_key;
            n            = active_size();
            first_key    = table_key[0];
            last_key     = table_key[n - 1];
            res.found    = 1'b0;
            res.position = '0;
            case (mode_reg)
                MODE_LAST_LE, MODE_LEFT_LE, MODE_CLAMP_LE:
                begin
                    if (x > last_key)
                    begin
                        // Only the clamped mode answers above the table range.
                        if (mode_reg == MODE_CLAMP_LE)
                        begin
                            res.found    = 1'b1;
                            res.position = RES_POS_W'(n - 1);
                        end
                    end
                    else if (x >= first_key)
                    begin
                        lo = last_at_or_below(x, n);
                        // The leftmost mode walks back over the run of keys equal to x.
                        if (mode_reg == MODE_LEFT_LE)
                            while (lo > 0 && table_key[lo - 1] == x)
                                lo--;
                        res.found    = 1'b1;
                        res.position = RES_POS_W'(lo);
                    end
                end
                MODE_FIRST_GE:
                begin
                    if (x <= last_key)
                    begin
                        res.found = 1'b1;
                        if (x > first_key)
                            res.position = RES_POS_W'(bisect_ge(x, n, lo));
                    end
                end
                MODE_EXACT:
                begin
                    if (x <= last_key && x >= first_key)
                    begin
                        hi = bisect_ge(x, n, lo);
                        if (table_key[hi] == x)
                        begin
                            res.found    = 1'b1;
                            res.position = RES_POS_W'(hi);
                        end
                        else if (table_key[lo] == x)
                        begin
                            res.found    = 1'b1;
                            res.position = RES_POS_W'(lo);
                        end
                    end
                end
                default:
                begin
                    res.found = 1'b0;
                end
            endcase
            return res;
        endfunction

        // A write updates the table copy; a search queues its expected response.
        function void note_request(logic cmd, logic [ENTRY_POS_W-1:0] pos,
                                   logic [KEY_IN_W-1:0] key);
            if (cmd == CMD_WRITE)
                table_key[pos] = key[KEY_WIDTH-1:0];
            else
                awaited_results.insert(awaited_results.size(), locate(key[KEY_WIDTH-1:0]));
        endfunction

        function void check_response(logic found, logic [RES_POS_W-1:0] position, time stamp);
            search_result_t exp;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: response found=%0b position=%0d with no search pending",
                         stamp, found, position);
                return;
            end
            exp = awaited_results.pop_front();
            if (found !== exp.found)
            begin
                errors++;
                $display("%0t ns: found mismatch, expected %0b, actual %0b",
                         stamp, exp.found, found);
            end
            if (position !== exp.position)
            begin
                errors++;
                $display("%0t ns: result_position mismatch, expected %0d, actual %0d",
                         stamp, exp.position, position);
            end
        endfunction
    endclass

endpackage

@@ verif/tb_sorted_table_binary_search.sv @@
// Top-level testbench for the sorted table binary search block.
// Loads sorted, duplicate-heavy and unsorted tables, sweeps sizes and modes, checks each response.
// Depends on stbs_pkg, stbs_if, stbs_tb_pkg and the block itself.
module tb_sorted_table_binary_search;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;
    import stbs_tb_pkg::*;

    // Ways of filling the searched part of the table.
    localparam int STYLE_SPREAD   = 0;
    localparam int STYLE_DUPS     = 1;
    localparam int STYLE_EQUAL    = 2;
    localparam int STYLE_UNSORTED = 3;
    localparam int STYLE_EDGES    = 4;
    localparam int STYLE_KEEP     = 5;

    localparam int DRAIN_CYCLES      = 40;
    localparam int SEARCHES_PER_MODE = 2;
    localparam int ODD_MODE_SEARCHES = 1;
    localparam int TIMEOUT_NS        = 20_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct;
    int stall_pct;
    int profile_step;

    search_scoreboard sb;

    stbs_req_if req ();
    stbs_rsp_if rsp ();

    sorted_table_binary_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Response side: random stalls set at the falling edge.
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    // Every accepted response is checked against the oldest pending search.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            sb.check_response(rsp.found, rsp.result_position, $time);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Step through the idle patterns: none, sender gaps, receiver stalls, both.
    task automatic next_profile();
        case (profile_step % 4)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 45;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 45;
            end
            default:
            begin
                send_idle_pct = 29;
                stall_pct     = 29;
            end
        endcase
        profile_step++;
    endtask

    // Present one request, with random gaps ahead of it, and hold it until taken.
    task automatic send_request(logic cmd, logic [ENTRY_POS_W-1:0] pos,
                                logic [KEY_IN_W-1:0] key);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid          <= 1'b1;
        req.command        <= cmd;
        req.entry_position <= pos;
        req.key_value      <= key;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        sb.note_request(cmd, pos, key);
    endtask

    // Drop valid, then wait for every pending response and a quiet stretch.
    task automatic wait_idle();
        @(negedge clk);
        req.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(index, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Fill positions 0 to n-1 in the given style; sorted styles but the all-equal one climb by random steps.
    task automatic load_table(int n, int style);
        logic [63:0]         acc;
        logic [31:0]         span;
        logic [KEY_IN_W-1:0] k;
        int                  i;
        span = 32'(64'h1_0000_0000 / (n + 1));
        acc  = (style == STYLE_EDGES) ? 64'd0 : 64'($urandom_range(span));
        for (i = 0; i < n; i++)
        begin
            if (i > 0 && style != STYLE_EQUAL)
            begin
                if ($urandom_range(99) >= ((style == STYLE_DUPS) ? 50 : 12))
                    acc = acc + $urandom_range(span, 1);
            end
            if (acc > 64'hFFFF_FFFF)
                acc = 64'hFFFF_FFFF;
            k = acc[31:0];
            if (style == STYLE_UNSORTED)
                k = $urandom;
            if (style == STYLE_EDGES && i == n - 1)
                k = '1;
            send_request(CMD_WRITE, ENTRY_POS_W'(i), k);
        end
    endtask

    // Search keys mostly hit stored keys or their neighbors, with some extremes.
    function automatic logic [KEY_IN_W-1:0] pick_key(int n);
        int roll;
        int idx;
        roll = $urandom_range(99);
        idx  = $urandom_range(n - 1);
        if (roll < 45)
            return sb.table_key[idx];
        if (roll < 55)
            return sb.table_key[idx] + 1;
        if (roll < 65)
            return sb.table_key[idx] - 1;
        if (roll < 71)
            return '0;
        if (roll < 77)
            return '1;
        return $urandom;
    endfunction

    // Mostly searches; a few stray writes, rarely one inside the searched range.
    task automatic issue_random_request(int n);
        int roll;
        roll = $urandom_range(99);
        if (roll < 4 && n < TABLE_DEPTH)
            send_request(CMD_WRITE, ENTRY_POS_W'($urandom_range(TABLE_DEPTH - 1, n)), $urandom);
        else if (roll < 5)
            send_request(CMD_WRITE, ENTRY_POS_W'($urandom_range(n - 1)), $urandom);
        else
            send_request(CMD_SEARCH, ENTRY_POS_W'($urandom_range(TABLE_DEPTH - 1)), pick_key(n));
    endtask

    // One table size: optional reload, then a burst of searches in every mode.
    task automatic run_size(int size_value, int style);
        logic [MODE_W-1:0] modes [6];
        int                n;
        int                m;
        modes = '{MODE_LAST_LE, MODE_LEFT_LE, MODE_CLAMP_LE, MODE_FIRST_GE, MODE_EXACT,
                  MODE_EXACT};
        modes[5] = MODE_W'($urandom_range({MODE_W{1'b1}}, MODE_EXACT + 1));
        n = (size_value == 0) ? 1 : ((size_value > TABLE_DEPTH) ? TABLE_DEPTH : size_value);
        wait_idle();
        write_reg(REG_TABLE_SIZE, CFG_DATA_W'(size_value));
        if (style != STYLE_KEEP)
            load_table(n, style);
        for (m = 0; m < 6; m++)
        begin
            next_profile();
            wait_idle();
            write_reg(REG_SEARCH_MODE, CFG_DATA_W'(modes[m]));
            repeat ((m == 5) ? ODD_MODE_SEARCHES : SEARCHES_PER_MODE)
                issue_random_request(n);
        end
    endtask

    // Four-entry table with a repeated last key, probed below, inside and above in each mode.
    task automatic run_directed();
        logic [KEY_IN_W-1:0] probes [4];
        logic [MODE_W-1:0]   modes [6];
        int                  m;
        int                  p;
        probes = '{32'd0, 32'd5, 32'd9, 32'hFFFF_FFFF};
        modes  = '{MODE_LAST_LE, MODE_LEFT_LE, MODE_CLAMP_LE, MODE_FIRST_GE, MODE_EXACT,
                   {MODE_W{1'b1}}};
        write_reg(REG_TABLE_SIZE, CFG_DATA_W'(4));
        send_request(CMD_WRITE, '1, '1);
        send_request(CMD_WRITE, ENTRY_POS_W'(0), 32'd1);
        send_request(CMD_WRITE, ENTRY_POS_W'(1), 32'd5);
        send_request(CMD_WRITE, ENTRY_POS_W'(2), 32'd9);
        send_request(CMD_WRITE, ENTRY_POS_W'(3), 32'd9);
        for (m = 0; m < 6; m++)
        begin
            wait_idle();
            write_reg(REG_SEARCH_MODE, CFG_DATA_W'(modes[m]));
            for (p = 0; p < 4; p++)
                send_request(CMD_SEARCH, (p % 2 == 0) ? '0 : '1, probes[p]);
        end
    endtask

    initial
    begin
        sb                 = new();
        req.valid          = 1'b0;
        req.command        = CMD_WRITE;
        req.entry_position = '0;
        req.key_value      = '0;
        rsp.ready          = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_TABLE_SIZE;
        cfg_data           = '0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        profile_step       = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // The full fill comes first, so every later search reads written entries only.
        run_size(TABLE_DEPTH, STYLE_SPREAD);
        run_size((1 << SIZE_W) - 1, STYLE_KEEP);
        run_size(777, STYLE_KEEP);
        run_size(0, STYLE_SPREAD);
        run_size(1, STYLE_EDGES);
        run_size(2, STYLE_DUPS);
        run_size(3, STYLE_SPREAD);
        run_size(5, STYLE_EDGES);
        run_size(8, STYLE_DUPS);
        run_size(17, STYLE_EQUAL);
        run_size(33, STYLE_SPREAD);
        run_size(40, STYLE_DUPS);
        run_size(40, STYLE_EDGES);
        run_size(31, STYLE_UNSORTED);

        wait_idle();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sorted_table_binary_search.f @@
rtl/stbs_pkg.sv
rtl/stbs_if.sv
rtl/stbs_ram.sv
rtl/stbs_dp.sv
rtl/stbs_ctrl.sv
rtl/sorted_table_binary_search.sv
verif/stbs_tb_pkg.sv
verif/tb_sorted_table_binary_search.sv
